FILE: rtl/c2p_pkg.sv
// shared types, constants and arctangent table of the cartesian to polar unit
package c2p_pkg;

  // coordinate and result widths
  localparam int DATA_WIDTH  = 16;
  localparam int ANGLE_WIDTH = 16;

  // fraction bits added to x and y before the micro-rotations
  localparam int GUARD = 4;
  // working x/y width: guard bits, sign, fold and cordic gain headroom
  localparam int X_WIDTH = DATA_WIDTH + GUARD + 3;

  // angle accumulator: radians times 2^Z_FRAC
  localparam int Z_FRAC  = 24;
  localparam int Z_WIDTH = Z_FRAC + 4;

  localparam int DEFAULT_ITERATIONS = 16;
  localparam int TABLE_SIZE         = 32;

  localparam logic signed [Z_WIDTH-1:0] PI_Z = Z_WIDTH'(52707179);

  // gain compensation 0.60725293500888 times 2^24
  localparam int GAIN_WIDTH = 24;
  localparam logic [GAIN_WIDTH-1:0] GAIN_COMP = GAIN_WIDTH'(10188014);

  localparam int ANGLE_LIMIT = 25736;

  // input transfer payload
  typedef struct packed {
    logic signed [DATA_WIDTH-1:0] x_in;
    logic signed [DATA_WIDTH-1:0] y_in;
  } c2p_in_t;

  // result transfer payload
  typedef struct packed {
    logic signed [ANGLE_WIDTH-1:0] angle;
    logic [DATA_WIDTH-1:0]         radius;
    logic                          domain_error;
  } c2p_out_t;

  // working vector handed from cell to cell
  typedef struct packed {
    logic                       err;
    logic signed [X_WIDTH-1:0]  x;
    logic signed [X_WIDTH-1:0]  y;
    logic signed [Z_WIDTH-1:0]  z;
  } c2p_vec_t;

  // round(atan(2^-idx) * 2^24)
  function automatic logic signed [Z_WIDTH-1:0] c2p_atan(input int idx);
    logic signed [Z_WIDTH-1:0] v;
    case (idx)
      0:  v = Z_WIDTH'(13176795);
      1:  v = Z_WIDTH'(7778716);
      2:  v = Z_WIDTH'(4110060);
      3:  v = Z_WIDTH'(2086331);
      4:  v = Z_WIDTH'(1047214);
      5:  v = Z_WIDTH'(524117);
      6:  v = Z_WIDTH'(262123);
      7:  v = Z_WIDTH'(131069);
      8:  v = Z_WIDTH'(65536);
      9:  v = Z_WIDTH'(32768);
      10: v = Z_WIDTH'(16384);
      11: v = Z_WIDTH'(8192);
      12: v = Z_WIDTH'(4096);
      13: v = Z_WIDTH'(2048);
      14: v = Z_WIDTH'(1024);
      15: v = Z_WIDTH'(512);
      16: v = Z_WIDTH'(256);
      17: v = Z_WIDTH'(128);
      18: v = Z_WIDTH'(64);
      19: v = Z_WIDTH'(32);
      20: v = Z_WIDTH'(16);
      21: v = Z_WIDTH'(8);
      22: v = Z_WIDTH'(4);
      23: v = Z_WIDTH'(2);
      24: v = Z_WIDTH'(1);
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

FILE: rtl/c2p_prep.sv
// input stage: zero detection, fold into the right half plane, guard bits
module c2p_prep import c2p_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  c2p_in_t  in_i,
  output logic     valid_o,
  output c2p_vec_t vec_o
);

  logic signed [X_WIDTH-1:0] x_ext, y_ext;
  logic                      valid_q;
  c2p_vec_t                  vec_d, vec_q;

  // sign extend to the working width
  assign x_ext = {{(X_WIDTH-DATA_WIDTH){in_i.x_in[DATA_WIDTH-1]}}, in_i.x_in};
  assign y_ext = {{(X_WIDTH-DATA_WIDTH){in_i.y_in[DATA_WIDTH-1]}}, in_i.y_in};

  // negative x: rotate by pi and start the angle at +-pi
  always_comb begin
    vec_d.err = (in_i.x_in == '0) && (in_i.y_in == '0);
    if (in_i.x_in[DATA_WIDTH-1]) begin
      vec_d.x = (-x_ext) <<< GUARD;
      vec_d.y = (-y_ext) <<< GUARD;
      vec_d.z = in_i.y_in[DATA_WIDTH-1] ? -PI_Z : PI_Z;
    end else begin
      vec_d.x = x_ext <<< GUARD;
      vec_d.y = y_ext <<< GUARD;
      vec_d.z = '0;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    vec_q <= vec_d;
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

FILE: rtl/c2p_cell.sv
// one cordic micro-rotation cell of the vectoring chain
module c2p_cell import c2p_pkg::*; #(
  parameter int STAGE = 0
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  c2p_vec_t vec_i,
  output logic     valid_o,
  output c2p_vec_t vec_o
);

  logic signed [X_WIDTH-1:0] x_s, y_s, dx, dy;
  logic signed [Z_WIDTH-1:0] z_s, step_angle;
  logic                      valid_q;
  c2p_vec_t                  vec_d, vec_q;

  assign x_s        = vec_i.x;
  assign y_s        = vec_i.y;
  assign z_s        = vec_i.z;
  assign dx         = y_s >>> STAGE;
  assign dy         = x_s >>> STAGE;
  assign step_angle = c2p_atan(STAGE);

  // rotate towards y = 0 and accumulate the angle
  always_comb begin
    vec_d.err = vec_i.err;
    if (!y_s[X_WIDTH-1]) begin
      vec_d.x = x_s + dx;
      vec_d.y = y_s - dy;
      vec_d.z = z_s + step_angle;
    end else begin
      vec_d.x = x_s - dx;
      vec_d.y = y_s + dy;
      vec_d.z = z_s - step_angle;
    end
  end

  // valid flag
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_i;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    vec_q <= vec_d;
  end

  assign valid_o = valid_q;
  assign vec_o   = vec_q;

endmodule

FILE: rtl/c2p_scale.sv
// output stages: gain compensation, angle rounding and saturation
module c2p_scale import c2p_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     valid_i,
  input  c2p_vec_t vec_i,
  output logic     valid_o,
  output c2p_out_t res_o
);

  localparam int PROD_WIDTH = X_WIDTH - 1 + GAIN_WIDTH;
  localparam int RAD_SHIFT  = Z_FRAC + GUARD;
  localparam int RAD_FULL_W = PROD_WIDTH - RAD_SHIFT;
  localparam int ANG_SHIFT  = Z_FRAC - 13;

  localparam logic [PROD_WIDTH-1:0]      RAD_ROUND = PROD_WIDTH'(1) << (RAD_SHIFT - 1);
  localparam logic signed [Z_WIDTH-1:0]  ANG_ROUND = Z_WIDTH'(1) << (Z_FRAC - 14);
  localparam logic signed [Z_WIDTH-1:0]  ANG_MAX   = Z_WIDTH'(ANGLE_LIMIT);

  logic signed [X_WIDTH-1:0]     x_s;
  logic [X_WIDTH-2:0]            x_mag;
  logic signed [Z_WIDTH-1:0]     z_s, ang_full;
  logic signed [ANGLE_WIDTH-1:0] ang_d, ang_q;
  logic [PROD_WIDTH-1:0]         prod_d, prod_q, prod_rnd;
  logic [RAD_FULL_W-1:0]         rad_full;
  logic [DATA_WIDTH-1:0]         rad_sat;
  logic                          rad_zero_d, rad_zero_q, err_q;
  logic                          valid1_q, valid2_q;
  c2p_out_t                      res_d, res_q;

  // first stage: gain multiply, angle rounding and clamp
  assign x_s        = vec_i.x;
  assign z_s        = vec_i.z;
  assign x_mag      = x_s[X_WIDTH-2:0];
  assign rad_zero_d = x_s[X_WIDTH-1] || (x_s == '0);
  assign prod_d     = PROD_WIDTH'(x_mag) * PROD_WIDTH'(GAIN_COMP);
  assign ang_full   = (z_s + ANG_ROUND) >>> ANG_SHIFT;

  always_comb begin
    if (ang_full > ANG_MAX) begin
      ang_d = ANGLE_WIDTH'(ANG_MAX);
    end else if (ang_full < -ANG_MAX) begin
      ang_d = ANGLE_WIDTH'(-ANG_MAX);
    end else begin
      ang_d = ang_full[ANGLE_WIDTH-1:0];
    end
  end

  // second stage: round and saturate the radius, apply the zero point case
  assign prod_rnd = prod_q + RAD_ROUND;
  assign rad_full = prod_rnd[PROD_WIDTH-1:RAD_SHIFT];

  always_comb begin
    if (rad_zero_q) begin
      rad_sat = '0;
    end else if (|rad_full[RAD_FULL_W-1:DATA_WIDTH]) begin
      rad_sat = '1;
    end else begin
      rad_sat = rad_full[DATA_WIDTH-1:0];
    end
  end

  always_comb begin
    if (err_q) begin
      res_d.angle        = '0;
      res_d.radius       = '0;
      res_d.domain_error = 1'b1;
    end else begin
      res_d.angle        = ang_q;
      res_d.radius       = rad_sat;
      res_d.domain_error = 1'b0;
    end
  end

  // valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid1_q <= 1'b0;
      valid2_q <= 1'b0;
    end else begin
      valid1_q <= valid_i;
      valid2_q <= valid1_q;
    end
  end

  // payload
  always_ff @(posedge clk_i) begin
    prod_q     <= prod_d;
    ang_q      <= ang_d;
    rad_zero_q <= rad_zero_d;
    err_q      <= vec_i.err;
    res_q      <= res_d;
  end

  assign valid_o = valid2_q;
  assign res_o   = res_q;

endmodule

FILE: rtl/cartesian_to_polar_unit.sv
// Cartesian to polar conversion top level: input stage, cordic cell chain, output stages.
// Each point is registered in the input stage, every cordic cell and both output stages.
// Throughput: one point per cycle; busy is never raised, the cell chain is fully pipelined.
// Each result is shown for one cycle with result_valid_o; the receiver cannot stall.
// Reset clears the valid flags of all stages; data in flight is dropped.
module cartesian_to_polar_unit import c2p_pkg::*; #(
  parameter int ITERATIONS = DEFAULT_ITERATIONS
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start,
  output logic     busy,
  input  c2p_in_t  in_i,
  output logic     result_valid_o,
  output c2p_out_t result_o
);

  localparam int LATENCY = ITERATIONS + 3;

  logic     accept;
  logic     chain_valid [ITERATIONS+1];
  c2p_vec_t chain_vec   [ITERATIONS+1];

  // a new point is taken every cycle
  assign busy   = 1'b0;
  assign accept = start && !busy;

  // fold and scale the input transfer
  c2p_prep u_prep (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (accept),
    .in_i    (in_i),
    .valid_o (chain_valid[0]),
    .vec_o   (chain_vec[0])
  );

  // chain of micro-rotation cells
  for (genvar g = 0; g < ITERATIONS; g++) begin : g_cell
    c2p_cell #(
      .STAGE (g)
    ) u_cell (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (chain_valid[g]),
      .vec_i   (chain_vec[g]),
      .valid_o (chain_valid[g+1]),
      .vec_o   (chain_vec[g+1])
    );
  end

  // gain compensation and rounding
  c2p_scale u_scale (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (chain_valid[ITERATIONS]),
    .vec_i   (chain_vec[ITERATIONS]),
    .valid_o (result_valid_o),
    .res_o   (result_o)
  );

  // every result is matched by an earlier start transfer that ran through the whole pipeline
  a_fixed_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start, LATENCY))
    else $error("result without a matching input transfer");

  // the zero point gives zero angle and radius
  a_zero_point: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (result_valid_o && result_o.domain_error) |->
      (result_o.angle == '0) && (result_o.radius == '0))
    else $error("domain error with nonzero angle or radius");

  // angle stays within minus pi to pi
  a_angle_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |->
      ($signed(result_o.angle) <= ANGLE_WIDTH'(ANGLE_LIMIT)) &&
      ($signed(result_o.angle) >= -ANGLE_WIDTH'(ANGLE_LIMIT)))
    else $error("angle out of range");

  // the input stage follows every accepted transfer
  a_prep_valid: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> chain_valid[0])
    else $error("accepted transfer lost at the input stage");

endmodule
